@@ rtl/rdt_pkg.sv @@
`default_nettype none

package rdt_pkg;

	localparam int NUM_REGS_DEF    = 32;
	localparam int MAX_PROGRAM_DEF = 4096;

	// fixed field widths of the instruction and result ports
	localparam int REG_W     = 5;
	localparam int OUT_IDX_W = 12;
	localparam int PROD_W    = 13;

	localparam logic [PROD_W-1:0] NO_PRODUCER = {PROD_W{1'b1}};

	typedef struct packed {
		logic wr_en;
		logic clear;
	} tbl_ctl_t;

	typedef struct packed {
		logic advance;
		logic clear;
	} cnt_ctl_t;

endpackage

`default_nettype wire

@@ rtl/rdt_table.sv @@
`default_nettype none

module rdt_table #(
	parameter int NUM_REGS = rdt_pkg::NUM_REGS_DEF,
	parameter int ENTRY_W  = 24
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         rd_en,
	input  wire  [$clog2(NUM_REGS)-1:0] rd_addr_a,
	input  wire  [$clog2(NUM_REGS)-1:0] rd_addr_b,
	output logic [ENTRY_W-1:0]          rd_data_a,
	output logic [ENTRY_W-1:0]          rd_data_b,
	output logic [NUM_REGS-1:0]         valid,
	input  rdt_pkg::tbl_ctl_t           ctl,
	input  wire  [$clog2(NUM_REGS)-1:0] wr_addr,
	input  wire  [ENTRY_W-1:0]          wr_data
);

	logic [ENTRY_W-1:0]  mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [NUM_REGS-1:0] valid_d;

	// read returns the old entry when the same address is written in that cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

	always_comb begin
		valid_d = valid_q;
		if (ctl.clear) begin
			valid_d = '0;
		end
		if (ctl.wr_en) begin
			valid_d[wr_addr] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= valid_d;
		end
	end

	assign valid = valid_q;

endmodule

`default_nettype wire

@@ rtl/rdt_counter.sv @@
`default_nettype none

module rdt_counter #(
	parameter int MAX_PROGRAM = rdt_pkg::MAX_PROGRAM_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  rdt_pkg::cnt_ctl_t              ctl,
	output logic [$clog2(MAX_PROGRAM)-1:0] index,
	output logic                           overflow
);

	localparam int IW = $clog2(MAX_PROGRAM);
	localparam logic [IW-1:0] TOP = IW'(MAX_PROGRAM - 1);

	logic [IW-1:0] next_q;
	logic          last_q;
	logic          ovf_q;
	logic [IW-1:0] cur_next;
	logic          cur_last;
	logic          cur_ovf;
	logic [IW-1:0] next_d;
	logic          last_d;
	logic          ovf_d;

	always_comb begin
		cur_next = ctl.clear ? '0 : next_q;
		cur_last = ctl.clear ? 1'b0 : last_q;
		cur_ovf  = ctl.clear ? 1'b0 : ovf_q;
		next_d   = cur_next;
		last_d   = cur_last;
		ovf_d    = cur_ovf;
		// saturate: the top index repeats, with overflow from its second use
		priority if (cur_next < TOP) begin
			next_d = cur_next + IW'(1);
		end else if (cur_last) begin
			ovf_d = 1'b1;
		end else begin
			last_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
			last_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (ctl.advance) begin
			next_q <= next_d;
			last_q <= last_d;
			ovf_q  <= ovf_d;
		end
	end

	assign index    = cur_next;
	assign overflow = ovf_d;

endmodule

`default_nettype wire

@@ rtl/raw_dependency_tracker.sv @@
`default_nettype none

// A request is registered in stage 1, then in the output register. Throughput:
// one request per cycle unless output stalls; the writer table has one write and
// two registered read ports; a same-cycle write is forwarded to the next request.
// Reset: asynchronous, clears the stage and output valids, the writer valid bits,
// the index counter and the overflow flag. Table entries are not cleared.
module raw_dependency_tracker #(
	parameter int NUM_REGS    = rdt_pkg::NUM_REGS_DEF,
	parameter int MAX_PROGRAM = rdt_pkg::MAX_PROGRAM_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire                                  start_of_program,
	input  wire         [rdt_pkg::REG_W-1:0]     dest_reg,
	input  wire         [rdt_pkg::REG_W-1:0]     first_source_reg,
	input  wire         [rdt_pkg::REG_W-1:0]     second_source_reg,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic        [rdt_pkg::OUT_IDX_W-1:0] inst_index,
	output logic signed [rdt_pkg::PROD_W-1:0]    first_producer,
	output logic signed [rdt_pkg::PROD_W-1:0]    second_producer,
	output logic        [rdt_pkg::OUT_IDX_W-1:0] dep_depth,
	output logic                                 index_overflow
);

	localparam int IW  = $clog2(MAX_PROGRAM);
	localparam int AW  = $clog2(NUM_REGS);
	localparam int EW  = 2 * IW;
	localparam logic [IW-1:0] TOP = IW'(MAX_PROGRAM - 1);

	// stage 1 registers
	logic                      valid_s1;
	logic                      start_s1;
	logic [rdt_pkg::REG_W-1:0] dst_s1;
	logic [rdt_pkg::REG_W-1:0] src_a_s1;
	logic [rdt_pkg::REG_W-1:0] src_b_s1;
	logic                      fwd_en_s1;
	logic [rdt_pkg::REG_W-1:0] fwd_reg_s1;
	logic [EW-1:0]             fwd_data_s1;

	// output registers
	logic                          out_valid_q;
	logic [rdt_pkg::OUT_IDX_W-1:0] index_q;
	logic [rdt_pkg::PROD_W-1:0]    prod_a_q;
	logic [rdt_pkg::PROD_W-1:0]    prod_b_q;
	logic [rdt_pkg::OUT_IDX_W-1:0] depth_q;
	logic                          ovf_q;

	logic              in_acc;
	logic              adv;
	logic [EW-1:0]     rd_a;
	logic [EW-1:0]     rd_b;
	logic [NUM_REGS-1:0] wvalid;
	rdt_pkg::tbl_ctl_t tbl_ctl;
	rdt_pkg::cnt_ctl_t cnt_ctl;
	logic [IW-1:0]     cur_idx;
	logic              cur_ovf;
	logic              dst_ok;
	logic              hit_a;
	logic              hit_b;
	logic [EW-1:0]     ent_a;
	logic [EW-1:0]     ent_b;
	logic [IW-1:0]     dmax;
	logic [IW-1:0]     res_depth;
	logic [EW-1:0]     wr_data;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	assign dst_ok          = 32'(dst_s1) < NUM_REGS;
	assign tbl_ctl.wr_en   = adv && dst_ok;
	assign tbl_ctl.clear   = adv && start_s1;
	assign cnt_ctl.advance = adv;
	assign cnt_ctl.clear   = start_s1;
	assign wr_data         = {cur_idx, res_depth};

	rdt_table #(
		.NUM_REGS (NUM_REGS),
		.ENTRY_W  (EW)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_acc),
		.rd_addr_a (AW'(first_source_reg)),
		.rd_addr_b (AW'(second_source_reg)),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b),
		.valid     (wvalid),
		.ctl       (tbl_ctl),
		.wr_addr   (AW'(dst_s1)),
		.wr_data   (wr_data)
	);

	rdt_counter #(
		.MAX_PROGRAM (MAX_PROGRAM)
	) u_counter (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (cnt_ctl),
		.index    (cur_idx),
		.overflow (cur_ovf)
	);

	always_comb begin
		// a write made while this request was read is not in the read data yet
		ent_a = (fwd_en_s1 && fwd_reg_s1 == src_a_s1) ? fwd_data_s1 : rd_a;
		ent_b = (fwd_en_s1 && fwd_reg_s1 == src_b_s1) ? fwd_data_s1 : rd_b;
		hit_a = !start_s1 && (32'(src_a_s1) < NUM_REGS) && wvalid[AW'(src_a_s1)];
		hit_b = !start_s1 && (32'(src_b_s1) < NUM_REGS) && wvalid[AW'(src_b_s1)];
		dmax  = '0;
		if (hit_a && ent_a[IW-1:0] > dmax) begin
			dmax = ent_a[IW-1:0];
		end
		if (hit_b && ent_b[IW-1:0] > dmax) begin
			dmax = ent_b[IW-1:0];
		end
		priority if (!hit_a && !hit_b) begin
			res_depth = '0;
		end else if (dmax >= TOP) begin
			res_depth = TOP;
		end else begin
			res_depth = dmax + IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			start_s1    <= start_of_program;
			dst_s1      <= dest_reg;
			src_a_s1    <= first_source_reg;
			src_b_s1    <= second_source_reg;
			fwd_en_s1   <= tbl_ctl.wr_en;
			fwd_reg_s1  <= dst_s1;
			fwd_data_s1 <= wr_data;
		end
		if (adv) begin
			index_q  <= rdt_pkg::OUT_IDX_W'(cur_idx);
			prod_a_q <= hit_a ? rdt_pkg::PROD_W'(ent_a[EW-1:IW]) : rdt_pkg::NO_PRODUCER;
			prod_b_q <= hit_b ? rdt_pkg::PROD_W'(ent_b[EW-1:IW]) : rdt_pkg::NO_PRODUCER;
			depth_q  <= rdt_pkg::OUT_IDX_W'(res_depth);
			ovf_q    <= cur_ovf;
		end
	end

	assign out_valid       = out_valid_q;
	assign inst_index      = index_q;
	assign first_producer  = prod_a_q;
	assign second_producer = prod_b_q;
	assign dep_depth       = depth_q;
	assign index_overflow  = ovf_q;

	a_depth_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !hit_a && !hit_b) |-> res_depth == '0)
		else $error("depth not zero without producers");

	a_prod_order: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && hit_a) |-> ent_a[EW-1:IW] <= cur_idx)
		else $error("producer index later than consumer");

	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && index_overflow) |-> inst_index == rdt_pkg::OUT_IDX_W'(TOP))
		else $error("overflow reported with unsaturated index");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
module tb_top;

	localparam int NREGS      = rdt_pkg::NUM_REGS_DEF;
	localparam int N_DIR      = 16;
	localparam int N_RANDOM   = 1000;
	localparam int N_LONG     = 700;
	localparam int N_TAIL     = 84;
	localparam int QUIET_MAX  = 2000;
	localparam logic [rdt_pkg::OUT_IDX_W-1:0] TOP_IDX =
		rdt_pkg::OUT_IDX_W'(rdt_pkg::MAX_PROGRAM_DEF - 1);
	localparam logic [rdt_pkg::PROD_W-1:0] NO_PROD = rdt_pkg::NO_PRODUCER;

	typedef logic [rdt_pkg::OUT_IDX_W-1:0] idx_t;
	typedef logic [rdt_pkg::REG_W-1:0]     reg_num_t;

	typedef struct packed {
		logic     start;
		reg_num_t dst;
		reg_num_t src_a;
		reg_num_t src_b;
	} instr_t;

	typedef struct packed {
		idx_t                              idx;
		logic signed [rdt_pkg::PROD_W-1:0] prod_a;
		logic signed [rdt_pkg::PROD_W-1:0] prod_b;
		idx_t                              depth;
		logic                              ovf;
	} dep_result_t;

	typedef struct packed {
		instr_t      ins;
		bit          known;
		dep_result_t res;
	} dir_row_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic                              start_of_program = 1'b0;
	reg_num_t                          dest_reg = '0;
	reg_num_t                          first_source_reg = '0;
	reg_num_t                          second_source_reg = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	idx_t                              inst_index;
	logic signed [rdt_pkg::PROD_W-1:0] first_producer;
	logic signed [rdt_pkg::PROD_W-1:0] second_producer;
	idx_t                              dep_depth;
	logic                              index_overflow;

	// last-writer table of the predictor
	bit [NREGS-1:0] wr_valid;
	idx_t           wr_idx [NREGS];
	idx_t           wr_depth [NREGS];
	idx_t           nxt_idx;
	bit             ovf_seen;
	bit             top_given;

	dep_result_t    pending_q [$];
	int             idle_pct = 33;
	int             stall_pct = 33;
	int             mismatch_cnt = 0;
	int             n_sent = 0;
	int             n_checked = 0;
	int             n_saturated = 0;
	int             deepest = 0;
	int             quiet_cycles = 0;

	raw_dependency_tracker i_dut (.*);

	always #1 clk = ~clk;

	function automatic dep_result_t predict_dependencies(input instr_t ins);
		dep_result_t r;
		bit          hit_a;
		bit          hit_b;
		idx_t        m;
		if (ins.start) begin
			wr_valid  = '0;
			nxt_idx   = '0;
			ovf_seen  = 1'b0;
			top_given = 1'b0;
		end
		r.idx = nxt_idx;
		if (nxt_idx < TOP_IDX) begin
			nxt_idx = nxt_idx + idx_t'(1);
		end else if (top_given) begin
			ovf_seen = 1'b1;
		end else begin
			top_given = 1'b1;
		end
		hit_a = (int'(ins.src_a) < NREGS) && wr_valid[ins.src_a];
		hit_b = (int'(ins.src_b) < NREGS) && wr_valid[ins.src_b];
		r.prod_a = hit_a ? {1'b0, wr_idx[ins.src_a]} : NO_PROD;
		r.prod_b = hit_b ? {1'b0, wr_idx[ins.src_b]} : NO_PROD;
		m = '0;
		if (hit_a && wr_depth[ins.src_a] > m) m = wr_depth[ins.src_a];
		if (hit_b && wr_depth[ins.src_b] > m) m = wr_depth[ins.src_b];
		if (!hit_a && !hit_b) begin
			r.depth = '0;
		end else begin
			r.depth = (m >= TOP_IDX) ? TOP_IDX : m + idx_t'(1);
		end
		// sources are looked up before the destination entry moves
		if (int'(ins.dst) < NREGS) begin
			wr_valid[ins.dst] = 1'b1;
			wr_idx[ins.dst]   = r.idx;
			wr_depth[ins.dst] = r.depth;
		end
		r.ovf = ovf_seen;
		return r;
	endfunction

	function automatic reg_num_t pick_reg();
		// bias toward a few hot registers so dependencies are common
		return $urandom_range(1) ? reg_num_t'($urandom_range(31)) : reg_num_t'($urandom_range(3));
	endfunction

	task automatic note_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
	endtask

	// present one request at the falling edge and hold it until accepted
	task automatic send_req(input instr_t ins, input bit known, input dep_result_t typed);
		dep_result_t pred;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid          <= 1'b1;
		start_of_program  <= ins.start;
		dest_reg          <= ins.dst;
		first_source_reg  <= ins.src_a;
		second_source_reg <= ins.src_b;
		do @(posedge clk); while (in_stall !== 1'b0);
		pred = predict_dependencies(ins);
		pending_q.insert(pending_q.size(), known ? typed : pred);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : result_check
		dep_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_q.size() == 0) begin
				note_mismatch($sformatf("result idx %0d with no request outstanding",
					inst_index));
			end else begin
				want = pending_q.pop_front();
				n_checked++;
				if (inst_index !== want.idx)
					note_mismatch($sformatf("inst_index exp %0d got %0d",
						want.idx, inst_index));
				if (first_producer !== want.prod_a)
					note_mismatch($sformatf("idx %0d first_producer exp %0d got %0d",
						want.idx, want.prod_a, first_producer));
				if (second_producer !== want.prod_b)
					note_mismatch($sformatf("idx %0d second_producer exp %0d got %0d",
						want.idx, want.prod_b, second_producer));
				if (dep_depth !== want.depth)
					note_mismatch($sformatf("idx %0d dep_depth exp %0d got %0d",
						want.idx, want.depth, dep_depth));
				if (index_overflow !== want.ovf)
					note_mismatch($sformatf("idx %0d index_overflow exp %0b got %0b",
						want.idx, want.ovf, index_overflow));
				if (want.ovf) n_saturated++;
				if (int'(want.depth) > deepest) deepest = int'(want.depth);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin : stimulus
		dir_row_t dir_tab [N_DIR];
		instr_t   ins;
		reg_num_t chain_reg;
		int i;
		// after reset, extremes, source equal to destination, start flag
		dir_tab = '{
			'{'{1'b0, 5'd0,  5'd0,  5'd31}, 1'b1, '{12'd0, NO_PROD, NO_PROD, 12'd0, 1'b0}},
			'{'{1'b0, 5'd31, 5'd0,  5'd31}, 1'b1, '{12'd1, 13'sd0, NO_PROD, 12'd1, 1'b0}},
			'{'{1'b0, 5'd5,  5'd31, 5'd31}, 1'b1, '{12'd2, 13'sd1, 13'sd1, 12'd2, 1'b0}},
			'{'{1'b0, 5'd5,  5'd5,  5'd0},  1'b1, '{12'd3, 13'sd2, 13'sd0, 12'd3, 1'b0}},
			'{'{1'b0, 5'd5,  5'd5,  5'd5},  1'b1, '{12'd4, 13'sd3, 13'sd3, 12'd4, 1'b0}},
			'{'{1'b1, 5'd10, 5'd5,  5'd0},  1'b1, '{12'd0, NO_PROD, NO_PROD, 12'd0, 1'b0}},
			'{'{1'b0, 5'd21, 5'd10, 5'd10}, 1'b1, '{12'd1, 13'sd0, 13'sd0, 12'd1, 1'b0}},
			'{'{1'b0, 5'd10, 5'd21, 5'd5},  1'b1, '{12'd2, 13'sd1, NO_PROD, 12'd2, 1'b0}},
			'{'{1'b1, 5'd31, 5'd31, 5'd31}, 1'b1, '{12'd0, NO_PROD, NO_PROD, 12'd0, 1'b0}},
			'{'{1'b0, 5'd10, 5'd21, 5'd10}, 1'b0, '0},
			'{'{1'b0, 5'd21, 5'd10, 5'd21}, 1'b0, '0},
			'{'{1'b0, 5'd31, 5'd31, 5'd0},  1'b0, '0},
			'{'{1'b0, 5'd0,  5'd31, 5'd31}, 1'b0, '0},
			'{'{1'b1, 5'd0,  5'd0,  5'd0},  1'b1, '{12'd0, NO_PROD, NO_PROD, 12'd0, 1'b0}},
			'{'{1'b0, 5'd0,  5'd0,  5'd0},  1'b1, '{12'd1, 13'sd0, 13'sd0, 12'd1, 1'b0}},
			'{'{1'b0, 5'd0,  5'd0,  5'd0},  1'b1, '{12'd2, 13'sd1, 13'sd1, 12'd2, 1'b0}}
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < N_DIR; i++) send_req(dir_tab[i].ins, dir_tab[i].known, dir_tab[i].res);

		// short programs with random content
		for (i = 0; i < N_RANDOM; i++) begin
			if (i == 300) begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			if (i == 550) begin
				idle_pct  = 33;
				stall_pct = 33;
			end
			if (i == 700) drain_results();
			ins.start = ($urandom_range(39) == 0);
			ins.dst   = pick_reg();
			ins.src_a = pick_reg();
			ins.src_b = pick_reg();
			send_req(ins, 1'b0, '0);
		end
		drain_results();

		// one long chained program: build a deep dependency chain
		chain_reg = reg_num_t'($urandom_range(31));
		for (i = 0; i < N_LONG; i++) begin
			ins.start = (i == 0);
			if ($urandom_range(1)) begin
				ins.src_a = chain_reg;
				ins.src_b = reg_num_t'($urandom_range(31));
			end else begin
				ins.src_a = reg_num_t'($urandom_range(31));
				ins.src_b = chain_reg;
			end
			if ($urandom_range(15) == 0) chain_reg = reg_num_t'($urandom_range(31));
			ins.dst = chain_reg;
			send_req(ins, 1'b0, '0);
		end

		// restart and run short programs again
		for (i = 0; i < N_TAIL; i++) begin
			ins.start = (i == 0) || ($urandom_range(29) == 0);
			ins.dst   = pick_reg();
			ins.src_a = pick_reg();
			ins.src_b = pick_reg();
			send_req(ins, 1'b0, '0);
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("Sent %0d instructions, checked %0d results (%0d with saturated index).",
			n_sent, n_checked, n_saturated);
		$display("Deepest dependency chain reported: %0d; mismatches: %0d.",
			deepest, mismatch_cnt);
		if (mismatch_cnt == 0 && pending_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/rdt_pkg.sv
rtl/rdt_table.sv
rtl/rdt_counter.sv
rtl/raw_dependency_tracker.sv
dv/tb_top.sv
